[design/sfpp_pkg.sv]
// ----------------------------------------------------------------------------
// sfpp_pkg
// shared constants and types of the sync framed packet parser
// ----------------------------------------------------------------------------
package sfpp_pkg;

    localparam int PAYLOAD_BYTES = 16;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int WORD_BYTES    = 4;

    localparam logic [7:0] SYNC_A = 8'h61;
    localparam logic [7:0] SYNC_5 = 8'h35;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic  valid;
        t_word bean_temp;
        t_word env_temp;
        t_word burn_value;
        t_word time_stamp;
        logic  checksum_ok;
    } t_result;

endpackage

[design/sfpp_core.sv]
// ----------------------------------------------------------------------------
// sfpp_core
// sync hunt, payload collection, checksum compare for one byte per step
// ----------------------------------------------------------------------------
module sfpp_core
    import sfpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_SYNC3 = 3'd2,
        PH_SYNC4 = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum,   n_sum;
    logic [7:0]       r_store [PAYLOAD_BYTES];
    logic             store_shift;
    t_word            words [WORD_BYTES];

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_sum       = r_sum;
        store_shift = 1'b0;
        unique case (r_phase)
            PH_SYNC1: n_phase = (i_byte == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2: n_phase = (i_byte == SYNC_5) ? PH_SYNC3 : PH_SYNC1;
            PH_SYNC3: n_phase = (i_byte == SYNC_5) ? PH_SYNC4 : PH_SYNC1;
            PH_SYNC4: begin
                if (i_byte == SYNC_A) begin
                    n_phase = PH_DATA;
                    n_count = '0;
                    n_sum   = '0;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_DATA: begin
                store_shift = 1'b1;
                n_sum       = r_sum + i_byte;
                n_count     = r_count + CNT_W'(1);
                if (r_count == CNT_W'(PAYLOAD_BYTES - 1)) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: n_phase = PH_SYNC1;
            default:  n_phase = (i_byte == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // oldest payload byte ends up at index 0
    always_ff @(posedge i_clk) begin
        if (i_step && store_shift) begin
            for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
                r_store[i] <= r_store[i+1];
            end
            r_store[PAYLOAD_BYTES-1] <= i_byte;
        end
    end

    always_comb begin
        for (int w = 0; w < WORD_BYTES; w++) begin
            words[w] = {r_store[WORD_BYTES*w],     r_store[WORD_BYTES*w + 1],
                        r_store[WORD_BYTES*w + 2], r_store[WORD_BYTES*w + 3]};
        end
    end

    assign o_res.valid       = i_step && (r_phase == PH_CHECK);
    assign o_res.bean_temp   = words[0];
    assign o_res.env_temp    = words[1];
    assign o_res.burn_value  = words[2];
    assign o_res.time_stamp  = words[3];
    assign o_res.checksum_ok = (i_byte == r_sum);

    a_check_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_CHECK) |=> (r_phase == PH_SYNC1))
        else $error("phase did not return to first sync after checksum");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_count < CNT_W'(PAYLOAD_BYTES)))
        else $error("payload count out of range");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_SYNC4 && i_byte == SYNC_A)
        |=> (r_phase == PH_DATA && r_count == '0 && r_sum == '0))
        else $error("frame start did not clear count and sum");

    a_full_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CHECK) |-> (r_count == CNT_W'(PAYLOAD_BYTES)))
        else $error("checksum phase without full payload");

endmodule

[design/sync_framed_packet_parser.sv]
// ----------------------------------------------------------------------------
// sync_framed_packet_parser
// byte stream frame parser: sync 'a','5','5','a', 16 payload bytes, checksum
// result path: checksum byte registered at the input, compared as it advances, result registered at the output
// throughput: one byte per cycle unless a held result waits on i_ready, set by the single parse step per byte
// reset: synchronous active low, returns to first sync state, no results held
// ----------------------------------------------------------------------------
module sync_framed_packet_parser
    import sfpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output t_word       o_bean_temp,
    output t_word       o_env_temp,
    output t_word       o_burn_value,
    output t_word       o_time_stamp,
    output logic        o_checksum_ok
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    sfpp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= res.valid;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && res.valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_bean_temp   = r_out.bean_temp;
    assign o_env_temp    = r_out.env_temp;
    assign o_burn_value  = r_out.burn_value;
    assign o_time_stamp  = r_out.time_stamp;
    assign o_checksum_ok = r_out.checksum_ok;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// frame parser bench: drives byte requests with random gaps, predicts each
// decoded frame in a scoreboard and compares every field of every result
// ----------------------------------------------------------------------------
module tb;
    import sfpp_pkg::*;

    localparam int TOTAL_BYTES  = 1600;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        t_word bean;
        t_word env;
        t_word burn;
        t_word stamp;
        logic  ok;
    } t_frame;

    class frame_scoreboard;
        typedef enum logic [2:0] {
            HUNT_A,
            HUNT_5A,
            HUNT_5B,
            HUNT_A2,
            IN_PAYLOAD,
            AT_CHECKSUM
        } t_phase;

        t_phase     phase;
        int         count;
        logic [7:0] sum;
        logic [7:0] payload [PAYLOAD_BYTES];
        t_frame     pending_frames [$];
        int         errors;
        int         frames_good;
        int         frames_bad;

        function new();
            phase       = HUNT_A;
            count       = 0;
            sum         = '0;
            errors      = 0;
            frames_good = 0;
            frames_bad  = 0;
            foreach (payload[i]) payload[i] = '0;
        endfunction

        function t_word word_of(int base);
            return {payload[base], payload[base+1], payload[base+2], payload[base+3]};
        endfunction

        function void take_byte(logic [7:0] b);
            t_frame f;
            case (phase)
                HUNT_5A: phase = (b == SYNC_5) ? HUNT_5B : HUNT_A;
                HUNT_5B: phase = (b == SYNC_5) ? HUNT_A2 : HUNT_A;
                HUNT_A2: begin
                    if (b == SYNC_A) begin
                        phase = IN_PAYLOAD;
                        count = 0;
                        sum   = '0;
                    end else begin
                        phase = HUNT_A;
                    end
                end
                IN_PAYLOAD: begin
                    payload[count] = b;
                    sum   = sum + b;
                    count = count + 1;
                    if (count >= PAYLOAD_BYTES) phase = AT_CHECKSUM;
                end
                AT_CHECKSUM: begin
                    f.bean  = word_of(0);
                    f.env   = word_of(4);
                    f.burn  = word_of(8);
                    f.stamp = word_of(12);
                    f.ok    = (b == sum);
                    pending_frames.push_back(f);
                    phase = HUNT_A;
                end
                default: phase = (b == SYNC_A) ? HUNT_5A : HUNT_A;
            endcase
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
            if (errors < MAX_REPORTS)
                $display("error: %s expected %h got %h", what, exp_v, act_v);
            errors++;
        endfunction

        function void check_frame(t_word bean, t_word env, t_word burn, t_word stamp,
                                  logic ok);
            t_frame e;
            if (pending_frames.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("error: unexpected result bean %h ok %b", bean, ok);
                errors++;
                return;
            end
            e = pending_frames.pop_front();
            if (bean !== e.bean)   report("bean_temp", e.bean, bean);
            if (env !== e.env)     report("env_temp", e.env, env);
            if (burn !== e.burn)   report("burn_value", e.burn, burn);
            if (stamp !== e.stamp) report("time_stamp", e.stamp, stamp);
            if (ok !== e.ok)       report("checksum_ok", 32'(e.ok), 32'(ok));
            if (e.ok) frames_good++;
            else frames_bad++;
        endfunction

        function int pending_count();
            return pending_frames.size();
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ready   = 1'b0;
    logic        o_ready;
    logic        o_valid;
    t_word       o_bean_temp;
    t_word       o_env_temp;
    t_word       o_burn_value;
    t_word       o_time_stamp;
    logic        o_checksum_ok;

    frame_scoreboard sb;
    bit              calm = 1'b1;
    int              bytes_sent = 0;
    int              idle_cycles = 0;
    int              stall_left = 0;
    bit              paused_once = 1'b0;

    wire in_fire  = i_valid & o_ready;
    wire out_fire = o_valid & i_ready;

    sync_framed_packet_parser u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_bean_temp  (o_bean_temp),
        .o_env_temp   (o_env_temp),
        .o_burn_value (o_burn_value),
        .o_time_stamp (o_time_stamp),
        .o_checksum_ok(o_checksum_ok)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 99) < 55) return 0;
        return gap_len();
    endfunction

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            3:       return 8'h7f;
            4:       return SYNC_A;
            5:       return SYNC_5;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] other_than(logic [7:0] avoid);
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == avoid);
        return v;
    endfunction

    // receiver side stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left <= gap_len() - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_fire)
            sb.check_frame(o_bean_temp, o_env_temp, o_burn_value, o_time_stamp,
                           o_checksum_ok);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    task automatic send_frame(input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        push_byte(SYNC_A);
        push_byte(SYNC_5);
        push_byte(SYNC_5);
        push_byte(SYNC_A);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            b   = payload_byte();
            sum = sum + b;
            push_byte(b);
        end
        push_byte(good ? sum : sum + 8'($urandom_range(1, 255)));
    endtask

    task automatic send_noise();
        int n;
        int r;
        n = $urandom_range(1, 8);
        repeat (n) begin
            r = $urandom_range(0, 9);
            if (r < 4) push_byte(SYNC_A);
            else if (r < 7) push_byte(SYNC_5);
            else push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_broken();
        int depth;
        depth = $urandom_range(1, 4);
        push_byte(SYNC_A);
        if (depth == 1) begin
            push_byte(other_than(SYNC_5));
        end else begin
            push_byte(SYNC_5);
            if (depth == 2) begin
                push_byte(other_than(SYNC_5));
            end else begin
                push_byte(SYNC_5);
                if (depth == 3) begin
                    push_byte(other_than(SYNC_A));
                end else begin
                    // sync completes but the payload stops short
                    push_byte(SYNC_A);
                    repeat ($urandom_range(1, PAYLOAD_BYTES - 1)) push_byte(payload_byte());
                end
            end
        end
    endtask

    initial begin
        logic [7:0] edge_bytes [$];
        logic [7:0] sum;
        int         r;

        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bad fourth sync, second sync byte not rechecked as first, bad third sync
        edge_bytes = '{SYNC_A, SYNC_5, SYNC_5, SYNC_5, SYNC_A, SYNC_A,
                       SYNC_A, SYNC_5, 8'h00};
        foreach (edge_bytes[i]) push_byte(edge_bytes[i]);

        // zero, minus one, most negative and most positive words, bad checksum
        edge_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
                       8'h80, 8'h00, 8'h00, 8'h00, 8'h7f, 8'hff, 8'hff, 8'hff};
        sum = '0;
        push_byte(SYNC_A);
        push_byte(SYNC_5);
        push_byte(SYNC_5);
        push_byte(SYNC_A);
        foreach (edge_bytes[i]) begin
            sum = sum + edge_bytes[i];
            push_byte(edge_bytes[i]);
        end
        push_byte(sum + 8'h01);
        wait_drained();

        while (bytes_sent < TOTAL_BYTES) begin
            calm = (bytes_sent < 200) || (bytes_sent >= 1000 && bytes_sent < 1200);
            if (!paused_once && bytes_sent >= 800) begin
                wait_drained();
                paused_once = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 75) send_frame($urandom_range(0, 99) < 80);
            else if (r < 88) send_noise();
            else send_broken();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d bytes sent, %0d frames checked (%0d checksum good, %0d bad)",
                 bytes_sent, sb.frames_good + sb.frames_bad, sb.frames_good, sb.frames_bad);
        $display("run: %0d mismatching fields or stray results", sb.errors);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
design/sfpp_pkg.sv
design/sfpp_core.sv
design/sync_framed_packet_parser.sv
test/tb.sv
